/* hw/rtl/stq_pkg.sv */
`timescale 1ns / 1ps

package stq_pkg;

    // queue geometry
    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int LEN_W       = $clog2(TIMER_SLOTS + 1);
    localparam int TIME_W      = 48;

    localparam logic [TIME_W-1:0] IDLE_DEFAULT = TIME_W'(60000);

    // operation codes
    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_RESET = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_RUN   = 2'd3
    } func_t;

    // command word
    typedef struct packed {
        logic [1:0]        func;
        logic [3:0]        slot_id;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] now_time;
    } cmd_t;

    // result word
    typedef struct packed {
        logic              fired;
        logic [3:0]        fired_slot;
        logic              run_again;
        logic              head_changed;
        logic [TIME_W-1:0] time_to_next;
        logic [4:0]        queued_total;
    } res_t;

    // one queue position
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] expiry;
    } entry_t;

    localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, slot: '0, expiry: '0};

    // controls broadcast to every cell
    typedef struct packed {
        logic              remove;
        logic              insert;
        logic [SLOT_W-1:0] target;
        entry_t            new_entry;
    } chain_ctrl_t;

    // status seen by the sequencer
    typedef struct packed {
        entry_t head;
        logic   removed;
    } chain_stat_t;

endpackage

/* hw/rtl/stq_expiry_mem.sv */
`timescale 1ns / 1ps

module stq_expiry_mem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [stq_pkg::SLOT_W-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [stq_pkg::SLOT_W-1:0] wr_addr,
    input  logic [stq_pkg::TIME_W-1:0] wr_data,
    output logic [stq_pkg::TIME_W-1:0] rd_data
);
    import stq_pkg::*;

    logic [TIME_W-1:0]      mem [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] written_reg;
    logic [TIMER_SLOTS-1:0] written_next;
    logic [TIME_W-1:0]      rd_data_reg;
    logic                   rd_written_reg;

    // entries never written read as zero
    always_comb
    begin
        written_next = written_reg;
        if (wr_en)
        begin
            written_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            written_reg <= written_next;
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/stq_cell.sv */
`timescale 1ns / 1ps

module stq_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stq_pkg::chain_ctrl_t ctrl,
    input  logic                 shift_left,
    input  stq_pkg::entry_t      left_entry,
    input  stq_pkg::entry_t      right_entry,
    input  logic                 left_behind,
    output logic                 behind,
    output logic                 match,
    output stq_pkg::entry_t      entry
);
    import stq_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [TIME_W-1:0] expiry_reg;
    logic [TIME_W-1:0] expiry_next;

    // strict compare: a new word goes behind equal expiries
    assign behind = !valid_reg || (ctrl.new_entry.expiry < expiry_reg);
    assign match  = valid_reg && (slot_reg == ctrl.target);

    always_comb
    begin
        valid_next  = valid_reg;
        slot_next   = slot_reg;
        expiry_next = expiry_reg;
        if (ctrl.remove && shift_left)
        begin
            valid_next  = right_entry.valid;
            slot_next   = right_entry.slot;
            expiry_next = right_entry.expiry;
        end
        else if (ctrl.insert && behind)
        begin
            if (left_behind)
            begin
                valid_next  = left_entry.valid;
                slot_next   = left_entry.slot;
                expiry_next = left_entry.expiry;
            end
            else
            begin
                valid_next  = 1'b1;
                slot_next   = ctrl.new_entry.slot;
                expiry_next = ctrl.new_entry.expiry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        expiry_reg <= expiry_next;
    end

    assign entry = '{valid: valid_reg, slot: slot_reg, expiry: expiry_reg};

endmodule

/* hw/rtl/stq_chain.sv */
`timescale 1ns / 1ps

module stq_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stq_pkg::chain_ctrl_t ctrl,
    output stq_pkg::chain_stat_t stat
);
    import stq_pkg::*;

    entry_t                 entries [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] behind;
    logic [TIMER_SLOTS-1:0] match;
    logic [TIMER_SLOTS-1:0] shift;

    // slots are unique in the queue, so match is one-hot or zero;
    // its negation marks the matching cell and every cell after it
    assign shift = ctrl.remove ? ((~match) + TIMER_SLOTS'(1)) : '0;

    for (genvar i = 0; i < TIMER_SLOTS; i++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        logic   left_behind;

        if (i == 0)
        begin : g_first
            assign left_entry  = EMPTY_ENTRY;
            assign left_behind = 1'b0;
        end
        else
        begin : g_mid
            assign left_entry  = entries[i-1];
            assign left_behind = behind[i-1];
        end

        if (i == TIMER_SLOTS - 1)
        begin : g_last
            assign right_entry = EMPTY_ENTRY;
        end
        else
        begin : g_inner
            assign right_entry = entries[i+1];
        end

        stq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .shift_left  (shift[i]),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .left_behind (left_behind),
            .behind      (behind[i]),
            .match       (match[i]),
            .entry       (entries[i])
        );
    end

    assign stat.head    = entries[0];
    assign stat.removed = ctrl.remove && (|match);

endmodule

/* hw/rtl/sorted_timer_queue.sv */
// sorted timer queue: a set of timer slots, each with a 48-bit expiry, plus a
// queue of armed slots held in ascending expiry order in a row of cells (cell 0
// is the head); a slot re-inserted goes behind queued slots of equal expiry.
// each command word carries func (set, reset, stop, run), slot_id, delay and
// now_time and yields exactly one result word with fired/fired_slot,
// run_again, head_changed, time_to_next (idle_horizon when empty) and
// queued_total. sums saturate at 2^48-1; slot ids at or above the slot count
// leave the state alone. one command at a time: accept, a removal pass over
// the cell row, an insertion pass, then the result register is loaded; the
// load waits while an earlier result is stalled, and the next command is
// taken only once the result register has been loaded. the result register
// lets a new command in while a result still waits.
// idle_horizon is written through cfg_we/cfg_wdata; the user must write it
// only while no command is in flight, the block itself does not enforce it.
// it resets to 60000. no start-up sweep: commands are taken right after reset.
`timescale 1ns / 1ps

module sorted_timer_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  stq_pkg::cmd_t              cmd,
    output logic                       res_valid,
    input  logic                       res_ready,
    output stq_pkg::res_t              res,
    input  logic                       cfg_we,
    input  logic [stq_pkg::TIME_W-1:0] cfg_wdata
);
    import stq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REMOVE = 4'b0010,
        ST_INSERT = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    cmd_t              cmd_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              slot_ok_reg;
    logic              old_valid_reg;
    logic [SLOT_W-1:0] old_slot_reg;
    logic [TIME_W-1:0] new_exp_reg;
    logic [TIME_W-1:0] new_exp_next;
    logic              pop_reg;
    logic [SLOT_W-1:0] fired_slot_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              res_valid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic [TIME_W-1:0] idle_horizon_reg;

    logic              accept;
    logic              load_res;
    logic [SLOT_W+3:0] cmd_slot_ext;
    logic [SLOT_W-1:0] cmd_idx;
    logic              cmd_slot_ok;
    logic              is_run;
    logic              slot_op;
    logic              ins_op;
    logic              head_due;
    logic              pop;
    logic [TIME_W:0]   sum_now;
    logic [TIME_W:0]   sum_old;
    logic [TIME_W:0]   ttn_diff;
    logic [SLOT_W+3:0] fired_slot_ext;
    logic [LEN_W+4:0]  len_ext;
    logic [TIME_W-1:0] rd_data;
    chain_ctrl_t       chain_ctrl;
    chain_stat_t       chain_stat;

    // command decode, slot_id mapped onto the slot index range
    assign cmd_slot_ext = {{SLOT_W{1'b0}}, cmd.slot_id};
    assign cmd_idx      = cmd_slot_ext[SLOT_W-1:0];
    assign cmd_slot_ok  = cmd_slot_ext < (SLOT_W + 4)'(TIMER_SLOTS);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign load_res  = (state_reg == ST_FINISH) && (!res_valid_reg || res_ready);

    assign is_run  = (cmd_reg.func == FUNC_RUN);
    assign slot_op = slot_ok_reg && !is_run;
    assign ins_op  = slot_ok_reg &&
                     ((cmd_reg.func == FUNC_SET) || (cmd_reg.func == FUNC_RESET));

    // head expired against the command's time
    assign head_due = chain_stat.head.valid &&
                      (chain_stat.head.expiry <= cmd_reg.now_time);
    assign pop      = is_run && head_due;

    // saturating sums for set and reset
    assign sum_now = {1'b0, cmd_reg.now_time} + {1'b0, cmd_reg.delay};
    assign sum_old = {1'b0, rd_data} + {1'b0, cmd_reg.delay};

    always_comb
    begin
        case (cmd_reg.func)
            FUNC_SET:   new_exp_next = sum_now[TIME_W] ? '1 : sum_now[TIME_W-1:0];
            FUNC_RESET: new_exp_next = sum_old[TIME_W] ? '1 : sum_old[TIME_W-1:0];
            default:    new_exp_next = cmd_reg.now_time;
        endcase
    end

    // per-slot expiry store, read at accept, written in the removal pass
    stq_expiry_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (cmd_idx),
        .wr_en   ((state_reg == ST_REMOVE) && slot_op),
        .wr_addr (idx_reg),
        .wr_data (new_exp_next),
        .rd_data (rd_data)
    );

    // removal pass unqueues the addressed slot (or the due head on run),
    // insertion pass places the slot by its new expiry
    always_comb
    begin
        chain_ctrl.remove    = (state_reg == ST_REMOVE) && (slot_op || pop);
        chain_ctrl.insert    = (state_reg == ST_INSERT) && ins_op;
        chain_ctrl.target    = is_run ? chain_stat.head.slot : idx_reg;
        chain_ctrl.new_entry = '{valid: 1'b1, slot: idx_reg, expiry: new_exp_reg};
    end

    stq_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (chain_ctrl),
        .stat  (chain_stat)
    );

    // queue length bookkeeping
    always_comb
    begin
        len_next = len_reg;
        if (chain_ctrl.remove && chain_stat.removed)
        begin
            len_next = len_reg - LEN_W'(1);
        end
        else if (chain_ctrl.insert)
        begin
            len_next = len_reg + LEN_W'(1);
        end
    end

    // result word built from the head after both passes
    assign ttn_diff       = {1'b0, chain_stat.head.expiry} - {1'b0, cmd_reg.now_time};
    assign fired_slot_ext = {4'b0000, fired_slot_reg};
    assign len_ext        = {5'b00000, len_reg};

    always_comb
    begin
        res_next.fired        = pop_reg;
        res_next.fired_slot   = pop_reg ? fired_slot_ext[3:0] : 4'b0000;
        res_next.run_again    = pop_reg && head_due;
        res_next.head_changed = pop_reg ||
                                (ins_op && (!old_valid_reg ||
                                            (old_slot_reg != chain_stat.head.slot)));
        if (!chain_stat.head.valid)
        begin
            res_next.time_to_next = idle_horizon_reg;
        end
        else if (ttn_diff[TIME_W])
        begin
            res_next.time_to_next = '0;
        end
        else
        begin
            res_next.time_to_next = ttn_diff[TIME_W-1:0];
        end
        res_next.queued_total = len_ext[4:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE: state_next = ST_INSERT;
            ST_INSERT: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (load_res)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            len_reg          <= '0;
            res_valid_reg    <= 1'b0;
            idle_horizon_reg <= IDLE_DEFAULT;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                idle_horizon_reg <= cfg_wdata;
            end
        end
    end

    // command and working payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= cmd;
            idx_reg       <= cmd_idx;
            slot_ok_reg   <= cmd_slot_ok;
            old_valid_reg <= chain_stat.head.valid;
            old_slot_reg  <= chain_stat.head.slot;
        end
        if (state_reg == ST_REMOVE)
        begin
            new_exp_reg    <= new_exp_next;
            pop_reg        <= pop;
            fired_slot_reg <= chain_stat.head.slot;
        end
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* hw/rtl/stq_checker.sv */
`timescale 1ns / 1ps

module stq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input logic          res_valid,
    input logic          res_ready,
    input stq_pkg::res_t res
);
    import stq_pkg::*;

    // a waiting result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // one command in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is in flight");

    // no pop means no slot and no follow-up
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.fired |-> !res.run_again && (res.fired_slot == 4'b0000))
        else $error("fired_slot or run_again set without a pop");

    // a due head after a pop leaves nothing to wait for
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.run_again |-> (res.time_to_next == '0) && res.head_changed)
        else $error("run_again with nonzero time_to_next or unchanged head");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);
